// ===== hw/rtl/u2u8_pkg.sv =====
package u2u8_pkg;

    localparam int RES_SLOTS = 4;

    localparam logic [2:0] ST_OK              = 3'd0;
    localparam logic [2:0] ST_HIGH_AFTER_HIGH = 3'd1;
    localparam logic [2:0] ST_LOW_NO_HIGH     = 3'd2;
    localparam logic [2:0] ST_HIGH_NO_LOW     = 3'd3;
    localparam logic [2:0] ST_HIGH_AT_END     = 3'd4;

    localparam logic [7:0]  BOM_HI    = 8'hFE;
    localparam logic [7:0]  BOM_LO    = 8'hFF;
    localparam logic [15:0] SUR_MASK  = 16'hF800;
    localparam logic [15:0] SUR_BASE  = 16'hD800;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    typedef struct packed {
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       has_byte;
        logic       last_of_run;
        logic [2:0] status;
    } t_out_item;

    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       has_byte;
        logic [2:0] status;
    } t_res;

    typedef struct packed {
        t_res [RES_SLOTS-1:0] res;
        logic [1:0]           last_idx;
    } t_job;

endpackage

// ===== hw/rtl/u2u8_front.sv =====
module u2u8_front
    import u2u8_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic     i_cfg_wdata,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    input  logic     i_q_full,
    output logic     o_push,
    output t_job     o_job
);

    logic       r_default_big;
    logic       r_order_big;
    logic       r_pend_valid;
    logic [9:0] r_pend_bits;

    logic       n_order_big;
    logic       n_pend_valid;
    logic [9:0] n_pend_bits;
    logic       has_res;
    logic       accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept && has_res;

    always_comb begin
        logic        bom_be;
        logic        bom_le;
        logic        order;
        logic [15:0] unit;
        logic        is_sur;
        logic        emit;
        logic [2:0]  status;
        logic [20:0] cp;
        logic [9:0]  high;
        logic [7:0]  b0;
        logic [7:0]  b1;

        b0     = i_in_item.first_byte;
        b1     = i_in_item.second_byte;
        bom_be = (b0 == BOM_HI) && (b1 == BOM_LO);
        bom_le = (b0 == BOM_LO) && (b1 == BOM_HI);
        order  = bom_be ? 1'b1 : (bom_le ? 1'b0 : r_order_big);
        unit   = order ? {b0, b1} : {b1, b0};
        is_sur = (unit & SUR_MASK) == SUR_BASE;

        emit         = 1'b1;
        status       = ST_OK;
        cp           = {5'd0, unit};
        high         = '0;
        n_pend_valid = 1'b0;
        n_pend_bits  = '0;
        o_job        = '0;
        has_res      = 1'b1;

        if (is_sur && !unit[10]) begin
            emit         = 1'b0;
            status       = r_pend_valid ? ST_HIGH_AFTER_HIGH : ST_OK;
            n_pend_valid = 1'b1;
            n_pend_bits  = unit[9:0];
        end else if (is_sur) begin
            high   = r_pend_valid ? r_pend_bits : 10'd0;
            status = r_pend_valid ? ST_OK : ST_LOW_NO_HIGH;
            cp     = SUPP_BASE + {1'b0, high, unit[9:0]};
        end else begin
            status = r_pend_valid ? ST_HIGH_NO_LOW : ST_OK;
        end

        if (emit) begin
            for (int k = 0; k < RES_SLOTS; k++) begin
                o_job.res[k].has_byte = 1'b1;
                o_job.res[k].status   = status;
            end
            if (cp < 21'h80) begin
                o_job.res[0].utf8_byte = {1'b0, cp[6:0]};
                o_job.last_idx         = 2'd0;
            end else if (cp < 21'h800) begin
                o_job.res[0].utf8_byte = {3'b110, cp[10:6]};
                o_job.res[1].utf8_byte = {2'b10, cp[5:0]};
                o_job.last_idx         = 2'd1;
            end else if (cp < SUPP_BASE) begin
                o_job.res[0].utf8_byte = {4'b1110, cp[15:12]};
                o_job.res[1].utf8_byte = {2'b10, cp[11:6]};
                o_job.res[2].utf8_byte = {2'b10, cp[5:0]};
                o_job.last_idx         = 2'd2;
            end else begin
                o_job.res[0].utf8_byte = {5'b11110, cp[20:18]};
                o_job.res[1].utf8_byte = {2'b10, cp[17:12]};
                o_job.res[2].utf8_byte = {2'b10, cp[11:6]};
                o_job.res[3].utf8_byte = {2'b10, cp[5:0]};
                o_job.last_idx         = 2'd3;
            end
        end else begin
            // status-only results of a high surrogate
            if (r_pend_valid && i_in_item.end_of_text) begin
                o_job.res[0].status = ST_HIGH_AFTER_HIGH;
                o_job.res[1].status = ST_HIGH_AT_END;
                o_job.last_idx      = 2'd1;
            end else if (r_pend_valid) begin
                o_job.res[0].status = ST_HIGH_AFTER_HIGH;
            end else if (i_in_item.end_of_text) begin
                o_job.res[0].status = ST_HIGH_AT_END;
            end else begin
                has_res = 1'b0;
            end
        end

        n_order_big = order;
        if (i_in_item.end_of_text) begin
            n_order_big  = r_default_big;
            n_pend_valid = 1'b0;
            n_pend_bits  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_big <= 1'b1;
            r_order_big   <= 1'b1;
            r_pend_valid  <= 1'b0;
            r_pend_bits   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_default_big <= i_cfg_wdata;
            end
            if (accept) begin
                r_order_big  <= n_order_big;
                r_pend_valid <= n_pend_valid;
                r_pend_bits  <= n_pend_bits;
            end
        end
    end

endmodule

// ===== hw/rtl/u2u8_queue.sv =====
module u2u8_queue
    import u2u8_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/u2u8_back.sv =====
module u2u8_back
    import u2u8_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_job      i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      [1:0] r_idx;
    logic            r_valid;
    t_out_item       r_item;
    logic            load;
    logic            last;

    assign load        = !i_q_empty && (!r_valid || i_out_ready);
    assign last        = r_idx == i_head.last_idx;
    assign o_pop       = load && last;
    assign o_out_valid = r_valid;
    assign o_out_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.utf8_byte   <= i_head.res[r_idx].utf8_byte;
            r_item.has_byte    <= i_head.res[r_idx].has_byte;
            r_item.status      <= i_head.res[r_idx].status;
            r_item.last_of_run <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last ? 2'd0 : r_idx + 2'd1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/utf16_to_utf8_transcoder_core.sv =====
// utf16 to utf8 transcoder
// input channel: one utf-16 code unit per item (two raw bytes in stream order plus
//   an end-of-text flag), i_in_valid / o_in_ready
// output channel: one result per item, a utf-8 byte or a status-only result,
//   o_out_valid / i_out_ready; last_of_run marks the final result of an input item
// config: i_cfg_we / i_cfg_wdata write the start-of-text byte order (1 = big endian),
//   used after each end of text; reset sets it to big endian
// data path: the results of an accepted input item are written to the job queue, then
//   loaded one at a time from the queue head into the output register
// throughput: one input item per cycle while the job queue has room; the back end
//   sends one result per cycle while the receiver is ready, 1 to 4 results per item as
//   set by its utf-8 length; items that make no result (a held high surrogate) are not queued
// reset: queue and output register empty, byte order big endian, nothing pending
// receiver stall: the output register holds its result, the queue fills
//   (QUEUE_DEPTH jobs) and then o_in_ready drops until the back end drains
module utf16_to_utf8_transcoder_core
    import u2u8_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    t_job q_in;
    t_job q_head;

    u2u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_job       (q_in)
    );

    u2u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    u2u8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== hw/rtl/u2u8_checker.sv =====
module u2u8_checker
    import u2u8_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_ready,
    input logic      o_out_valid,
    input t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_item))
        else $error("output item changed while stalled");

    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.has_byte |->
            o_out_item.utf8_byte == 8'd0 &&
            (o_out_item.status == ST_HIGH_AFTER_HIGH || o_out_item.status == ST_HIGH_AT_END))
        else $error("malformed status-only result");

    a_byte_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.has_byte |->
            o_out_item.status != ST_HIGH_AT_END &&
            o_out_item.status != ST_HIGH_AFTER_HIGH)
        else $error("byte result with status-only code");

endmodule

bind utf16_to_utf8_transcoder_core u2u8_checker u_chk (.*);
